### rtl/ckoa_pkg.sv
// shared constants and types for the composite key ordinal assigner
package ckoa_pkg;

  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_MAX_COLUMNS = 4;
  localparam int IN_COLUMNS      = 4;
  localparam int COL_W           = 64;
  localparam int ORD_W           = 10;
  localparam int CNT_W           = 11;
  localparam int CFG_W           = 3;
  localparam int IN_TDATA_W      = 272;
  localparam int OUT_TDATA_W     = 280;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_ORD  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

endpackage

### rtl/composite_key_ordinal_assigner.sv
// dictionary encoder: first-seen ordinals for composite keys, with read-back
//
// in_*: one word per item; in_tuser carries the action (0 look up or insert,
//   1 read the stored key of read_ordinal). out_*: one result word per item.
// cfg_*: writes columns_in_use; always ready, write only while idle.
// Keys live in one synchronous memory, one row of all columns per ordinal.
// A lookup scans the rows in ordinal order, one row per cycle through the
//   single read port; a new key is written in the cycle the scan ends.
// A read item goes through S_READ to S_DONE, or straight to S_DONE when
//   the ordinal is not yet assigned, as does a lookup into the empty table.
// One item is in flight at a time; the next is taken once the block is back
//   in idle, which can be while the previous result still waits at the output.
// A stalled receiver holds the result in the output register; a finished
//   item waits in its last state until that register is free.
// Reset (synchronous, rst_n low) empties the table by clearing the entry
//   count and sets columns_in_use to 1; the memory itself is not cleared,
//   as rows are only read below the entry count.
module composite_key_ordinal_assigner
  import ckoa_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key_col0, key_col1, key_col2, key_col3, read_ordinal, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // ordinal, is_new, status, read_key_col0..3, stored_count
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int ROW_W = MAX_COLUMNS * COL_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_DONE} state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [CFG_W-1:0]  cols_r;
  logic [ROW_W-1:0]  key_r;
  logic [AW-1:0]     idx_r;
  logic [ROW_W-1:0]  rdata_r;
  logic [ROW_W-1:0]  mem [CAPACITY];
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  key_in;
  logic [CFG_W-1:0]  eff_cols;

  logic [ORD_W-1:0]  res_ord_r;
  logic              res_new_r;
  status_t           res_st_r;
  logic [IN_COLUMNS*COL_W-1:0] res_cols_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [31:0] ro32, cnt32, idx32, cap32;
  logic        accept, last_row, hit, out_free, no_ord;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign ro32  = 32'(in_tdata[IN_COLUMNS*COL_W +: ORD_W]);
  assign cnt32 = 32'(count_r);
  assign idx32 = 32'(idx_r);
  assign cap32 = 32'(CAPACITY);
  assign no_ord = (ro32 >= cnt32) || (ro32 >= cap32);

  // column count clamped to 1..MAX_COLUMNS
  always_comb begin
    eff_cols = cols_r;
    if (cols_r == '0) eff_cols = CFG_W'(1);
    if (32'(cols_r) > 32'(MAX_COLUMNS)) eff_cols = CFG_W'(MAX_COLUMNS);
  end

  always_comb begin
    key_in = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (c < IN_COLUMNS && 32'(c) < 32'(eff_cols)) begin
        key_in[c*COL_W +: COL_W] = in_tdata[(c % IN_COLUMNS)*COL_W +: COL_W];
      end
    end
  end

  assign hit      = (rdata_r == key_r);
  assign last_row = (idx32 + 32'd1 >= cnt32);

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_tuser == ACT_READ) ? ro32[AW-1:0] : '0;
    end else begin
      rd_addr = AW'(idx32 + 32'd1);
    end
  end

  assign wr_en = (state_r == S_SCAN && !hit && last_row && cnt32 < cap32) ||
                 (accept && in_tuser == ACT_LOOKUP && count_r == '0);

  // key store: one registered read port, one write port
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= (state_r == S_IDLE) ? key_in : key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cols_r      <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cols_r <= cfg_data;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) count_r <= count_r + CW'(1);
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r      <= key_in;
            idx_r      <= '0;
            res_cols_r <= '0;
            res_new_r  <= (in_tuser == ACT_LOOKUP) && (count_r == '0);
            res_st_r   <= (in_tuser == ACT_READ && no_ord) ? ST_NO_ORD : ST_OK;
            res_ord_r  <= (in_tuser == ACT_READ) ? ro32[ORD_W-1:0] : '0;
            if (in_tuser == ACT_READ) begin
              state_r <= no_ord ? S_DONE : S_READ;
            end else if (count_r == '0) begin
              // empty table: first key is new at ordinal zero
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_ord_r <= idx32[ORD_W-1:0];
            state_r   <= S_DONE;
          end else if (last_row) begin
            if (cnt32 < cap32) begin
              res_ord_r <= cnt32[ORD_W-1:0];
              res_new_r <= 1'b1;
            end else begin
              res_st_r <= ST_FULL;
            end
            state_r <= S_DONE;
          end else begin
            idx_r <= AW'(idx32 + 32'd1);
          end
        end
        S_READ: begin
          for (int c = 0; c < IN_COLUMNS; c++) begin
            if (c < MAX_COLUMNS) begin
              res_cols_r[c*COL_W +: COL_W] <= rdata_r[(c % MAX_COLUMNS)*COL_W +: COL_W];
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= {CNT_W'(cnt32), res_cols_r, res_st_r, res_new_r, res_ord_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
